>>> hw/rtl/saps_pkg.sv
// ----------------------------------------------------------------------------
// saps_pkg
// Shared widths, register indexes, constants and stage records for the
// sensor array PID steering block.
// ----------------------------------------------------------------------------
package saps_pkg;

    localparam int SENSOR_W = 5;
    localparam int SPEED_W  = 8;
    localparam int ERROR_W  = 5;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 10;
    localparam int INTEG_W  = 11;
    localparam int DERIV_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Product widths: a gain with a zero sign bit times a signed operand.
    localparam int PROD_P_W = GAIN_W + 1 + ERROR_W;
    localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
    localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PID_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd5;

    // Reset values of the configuration registers.
    localparam logic                RST_PID_MODE       = 1'b1;
    localparam logic [GAIN_W-1:0]   RST_PROP_GAIN      = 16'd10240;
    localparam logic [GAIN_W-1:0]   RST_INT_GAIN       = 16'd77;
    localparam logic [GAIN_W-1:0]   RST_DERIV_GAIN     = 16'd5120;
    localparam logic [SPEED_W-1:0]  RST_BASE_SPEED     = 8'd200;
    localparam logic [LIMIT_W-1:0]  RST_INTEGRAL_LIMIT = 10'd250;

    // Error offset: the weighted sum of all five sensors.
    localparam logic [ERROR_W-1:0] ERROR_OFFSET = 5'd15;

    // Speed quotient stage: u / 5 with u below SAT_U, done as (u * RECIP_5) >> 16.
    // The reciprocal is rounded up so that exact multiples of five do not
    // fall one short; the excess stays far below one step over this range.
    localparam int QUOT_W = 11;
    localparam int RECIP_W = 14;
    localparam int RECIP_PROD_W = QUOT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_5 = 14'd13108;
    localparam int SAT_U = 1280;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;

    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
        logic signed [ERROR_W-1:0]  e5;
    } t_prod_stage;

    typedef struct packed {
        logic              neg;
        logic              sat;
        logic [QUOT_W-1:0] u;
    } t_side;

    typedef struct packed {
        t_side                     left;
        t_side                     right;
        logic signed [ERROR_W-1:0] e5;
    } t_quot_stage;

endpackage

>>> hw/rtl/saps_in_if.sv
// ----------------------------------------------------------------------------
// saps_in_if
// Sensor sample channel: valid/ready handshake with one five-bit sample.
// ----------------------------------------------------------------------------
interface saps_in_if
    import saps_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SENSOR_W-1:0] sensor_bits;

    modport source (output valid, output sensor_bits, input ready);
    modport sink   (input valid, input sensor_bits, output ready);
endinterface

>>> hw/rtl/saps_out_if.sv
// ----------------------------------------------------------------------------
// saps_out_if
// Drive result channel: valid/ready handshake with both wheel levels and
// the scaled position error.
// ----------------------------------------------------------------------------
interface saps_out_if
    import saps_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [SPEED_W-1:0]        left_speed;
    logic [SPEED_W-1:0]        right_speed;
    logic signed [ERROR_W-1:0] error_scaled;

    modport source (output valid, output left_speed, output right_speed,
                    output error_scaled, input ready);
    modport sink   (input valid, input left_speed, input right_speed,
                    input error_scaled, output ready);
endinterface

>>> hw/rtl/sensor_array_pid_steering_top.sv
// ----------------------------------------------------------------------------
// sensor_array_pid_steering_top
// Path: a sample goes through stages 1, 2, 3 and the output register to o_drive.
// Throughput: one sample per cycle while o_drive accepts; the four stage registers
// each hold one transaction and advance independently, so bubbles absorb stalls.
// Reset: synchronous, active low; clears all stage valid bits, the integral
// and last error, and loads the configuration reset values.
// ----------------------------------------------------------------------------
module sensor_array_pid_steering_top
    import saps_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    saps_in_if.sink               i_sample,
    saps_out_if.source            o_drive
);

    // Pipeline overview.
    //   Stage 1 holds the raw sample. From it and the controller state the
    //   error, the clamped integral and the derivative are formed, and the
    //   three gain products are taken in parallel. The controller state is
    //   updated in PID mode when that transaction moves on to stage 2, so the next
    //   sample in stage 1 always sees the state left by the one before it.
    //   Stage 2 holds the products. They are summed into the numerator, the
    //   base level (scaled by 5 * 2^GAIN_FRAC_BITS) is offset by it for each
    //   wheel, and the result is shifted down by the fraction bits. Each side
    //   is classified as negative, saturated, or a small value below 1280.
    //   Stage 3 holds that classification; the small value is divided by five
    //   with a constant reciprocal, and the output register takes the level.

    // Widths that follow from the gain fraction.
    localparam int BASE5_W = SPEED_W + 3;
    localparam int BD_W    = BASE5_W + GAIN_FRAC_BITS;
    localparam int NUM_W   = PROD_I_W + 1;
    localparam int T_W     = ((BD_W + 1 > NUM_W) ? BD_W + 1 : NUM_W) + 1;

    // ------------------------------------------------------------------
    // Configuration registers and controller state.
    // ------------------------------------------------------------------
    logic                      r_pid_mode;
    logic [GAIN_W-1:0]         r_prop_gain;
    logic [GAIN_W-1:0]         r_int_gain;
    logic [GAIN_W-1:0]         r_deriv_gain;
    logic [SPEED_W-1:0]        r_base_speed;
    logic [LIMIT_W-1:0]        r_integral_limit;
    logic signed [INTEG_W-1:0] r_integral_sum;
    logic signed [ERROR_W-1:0] r_last_error;

    // ------------------------------------------------------------------
    // Stage registers and handshake.
    // ------------------------------------------------------------------
    logic                      r_v1;
    logic [SENSOR_W-1:0]       r_s1_bits;
    logic                      r_v2;
    t_prod_stage               r_s2;
    logic                      r_v3;
    t_quot_stage               r_s3;
    logic                      r_out_valid;
    logic [SPEED_W-1:0]        r_out_left;
    logic [SPEED_W-1:0]        r_out_right;
    logic signed [ERROR_W-1:0] r_out_error;

    logic w_rdy_o;
    logic w_rdy3;
    logic w_rdy2;
    logic w_rdy1;

    // A stage can take a new transaction when it is empty or its contents
    // move on in the same cycle.
    assign w_rdy_o = !r_out_valid || o_drive.ready;
    assign w_rdy3  = !r_v3 || w_rdy_o;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;

    assign i_sample.ready = w_rdy1;

    // ------------------------------------------------------------------
    // Stage 1 logic: error, integral, derivative and products.
    // ------------------------------------------------------------------
    logic [3:0]                 w_weight_sum;
    logic signed [ERROR_W-1:0]  w_e5;
    logic signed [INTEG_W:0]    w_integ_raw;
    logic signed [INTEG_W:0]    w_lim;
    logic signed [INTEG_W-1:0]  w_integ;
    logic signed [DERIV_W-1:0]  w_deriv;
    logic signed [INTEG_W-1:0]  w_integ_op;
    logic signed [DERIV_W-1:0]  w_deriv_op;
    logic signed [PROD_P_W-1:0] w_prod_p;
    logic signed [PROD_I_W-1:0] w_prod_i;
    logic signed [PROD_D_W-1:0] w_prod_d;

    always_comb begin
        w_weight_sum = 4'd0;
        for (int k = 0; k < SENSOR_W; k++) begin
            if (r_s1_bits[k]) begin
                w_weight_sum = w_weight_sum + 4'(k + 1);
            end
        end
        w_e5 = $signed({1'b0, w_weight_sum} - ERROR_OFFSET);

        // The integral is clamped to the limit as it stands now, so a lowered
        // limit takes effect on the next step.
        w_integ_raw = (INTEG_W + 1)'(r_integral_sum) + (INTEG_W + 1)'(w_e5);
        w_lim       = $signed({2'b00, r_integral_limit});
        priority if (w_integ_raw > w_lim) begin
            w_integ = INTEG_W'(w_lim);
        end else if (w_integ_raw < -w_lim) begin
            w_integ = INTEG_W'(-w_lim);
        end else begin
            w_integ = INTEG_W'(w_integ_raw);
        end
        w_deriv = DERIV_W'(w_e5) - DERIV_W'(r_last_error);

        // Proportional-only mode drops the integral and derivative terms.
        w_integ_op = r_pid_mode ? w_integ : '0;
        w_deriv_op = r_pid_mode ? w_deriv : '0;

        w_prod_p = $signed({1'b0, r_prop_gain})  * w_e5;
        w_prod_i = $signed({1'b0, r_int_gain})   * w_integ_op;
        w_prod_d = $signed({1'b0, r_deriv_gain}) * w_deriv_op;
    end

    // ------------------------------------------------------------------
    // Stage 2 logic: numerator, wheel offsets and classification.
    // ------------------------------------------------------------------
    logic [BASE5_W-1:0]    w_base5;
    logic [BD_W-1:0]       w_bd;
    logic signed [NUM_W-1:0] w_num;
    logic signed [T_W-1:0] w_bd_t;
    logic signed [T_W-1:0] w_num_t;
    logic signed [T_W-1:0] w_t_left;
    logic signed [T_W-1:0] w_t_right;
    logic signed [T_W-1:0] w_u_left;
    logic signed [T_W-1:0] w_u_right;
    logic signed [T_W-1:0] w_sat_u;
    t_quot_stage           w_s3_next;

    always_comb begin
        w_base5 = BASE5_W'(r_base_speed) * BASE5_W'(5);
        w_bd    = BD_W'(w_base5) << GAIN_FRAC_BITS;
        w_num   = NUM_W'($signed(r_s2.prod_p)) + NUM_W'($signed(r_s2.prod_i))
                + NUM_W'($signed(r_s2.prod_d));
        w_bd_t  = $signed({{(T_W - BD_W){1'b0}}, w_bd});
        w_num_t = T_W'(w_num);

        w_t_left  = w_bd_t - w_num_t;
        w_t_right = w_bd_t + w_num_t;

        // Floor division by 2^GAIN_FRAC_BITS first, then by five later;
        // the two floors compose into floor(t / (5 * 2^GAIN_FRAC_BITS)).
        w_u_left  = w_t_left >>> GAIN_FRAC_BITS;
        w_u_right = w_t_right >>> GAIN_FRAC_BITS;
        w_sat_u   = T_W'(SAT_U);

        w_s3_next.left.neg  = w_u_left[T_W-1];
        w_s3_next.left.sat  = !w_u_left[T_W-1] && (w_u_left >= w_sat_u);
        w_s3_next.left.u    = w_u_left[QUOT_W-1:0];
        w_s3_next.right.neg = w_u_right[T_W-1];
        w_s3_next.right.sat = !w_u_right[T_W-1] && (w_u_right >= w_sat_u);
        w_s3_next.right.u   = w_u_right[QUOT_W-1:0];
        w_s3_next.e5        = r_s2.e5;
    end

    // ------------------------------------------------------------------
    // Stage 3 logic: divide by five and saturate.
    // ------------------------------------------------------------------
    logic [RECIP_PROD_W-1:0] w_q_left;
    logic [RECIP_PROD_W-1:0] w_q_right;
    logic [SPEED_W-1:0]      w_speed_left;
    logic [SPEED_W-1:0]      w_speed_right;

    always_comb begin
        w_q_left  = RECIP_PROD_W'(r_s3.left.u)  * RECIP_PROD_W'(RECIP_5);
        w_q_right = RECIP_PROD_W'(r_s3.right.u) * RECIP_PROD_W'(RECIP_5);

        priority if (r_s3.left.neg) begin
            w_speed_left = '0;
        end else if (r_s3.left.sat) begin
            w_speed_left = SPEED_MAX;
        end else begin
            w_speed_left = w_q_left[16 +: SPEED_W];
        end

        priority if (r_s3.right.neg) begin
            w_speed_right = '0;
        end else if (r_s3.right.sat) begin
            w_speed_right = SPEED_MAX;
        end else begin
            w_speed_right = w_q_right[16 +: SPEED_W];
        end
    end

    // ------------------------------------------------------------------
    // Control registers: configuration, controller state, valid bits.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid_mode       <= RST_PID_MODE;
            r_prop_gain      <= RST_PROP_GAIN;
            r_int_gain       <= RST_INT_GAIN;
            r_deriv_gain     <= RST_DERIV_GAIN;
            r_base_speed     <= RST_BASE_SPEED;
            r_integral_limit <= RST_INTEGRAL_LIMIT;
            r_integral_sum   <= '0;
            r_last_error     <= '0;
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_v3             <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PID_MODE:       r_pid_mode       <= i_cfg_data[0];
                    CFG_PROP_GAIN:      r_prop_gain      <= i_cfg_data[GAIN_W-1:0];
                    CFG_INT_GAIN:       r_int_gain       <= i_cfg_data[GAIN_W-1:0];
                    CFG_DERIV_GAIN:     r_deriv_gain     <= i_cfg_data[GAIN_W-1:0];
                    CFG_BASE_SPEED:     r_base_speed     <= i_cfg_data[SPEED_W-1:0];
                    CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            // In PID mode, the state commits as the sample leaves stage 1.
            if (r_v1 && w_rdy2 && r_pid_mode) begin
                r_integral_sum <= w_integ;
                r_last_error   <= w_e5;
            end

            if (w_rdy1) begin
                r_v1 <= i_sample.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy_o) begin
                r_out_valid <= r_v3;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: loaded as a transaction enters each stage.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_sample.valid) begin
            r_s1_bits <= i_sample.sensor_bits;
        end
        if (w_rdy2 && r_v1) begin
            r_s2.prod_p <= w_prod_p;
            r_s2.prod_i <= w_prod_i;
            r_s2.prod_d <= w_prod_d;
            r_s2.e5     <= w_e5;
        end
        if (w_rdy3 && r_v2) begin
            r_s3 <= w_s3_next;
        end
        if (w_rdy_o && r_v3) begin
            r_out_left  <= w_speed_left;
            r_out_right <= w_speed_right;
            r_out_error <= r_s3.e5;
        end
    end

    assign o_drive.valid        = r_out_valid;
    assign o_drive.left_speed   = r_out_left;
    assign o_drive.right_speed  = r_out_right;
    assign o_drive.error_scaled = r_out_error;

endmodule

>>> hw/rtl/saps_checker.sv
// ----------------------------------------------------------------------------
// saps_checker
// Port-level checks on the steering block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module saps_checker
    import saps_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [SPEED_W-1:0]        i_left_speed,
    input logic [SPEED_W-1:0]        i_right_speed,
    input logic signed [ERROR_W-1:0] i_error_scaled
);

    // Reset empties the result register.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // With no result pending, every stage can advance, so the input is ready.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output empty");

    // The scaled error never goes above zero or below minus fifteen.
    a_error_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_error_scaled[ERROR_W-1] || (i_error_scaled == '0))
                        && (i_error_scaled != 5'b10000))
        else $error("scaled error out of range");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_left_speed)
            && $stable(i_right_speed) && $stable(i_error_scaled))
        else $error("stalled result changed");

endmodule

bind sensor_array_pid_steering_top saps_checker u_saps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_sample.ready),
    .i_out_valid    (o_drive.valid),
    .i_out_ready    (o_drive.ready),
    .i_left_speed   (o_drive.left_speed),
    .i_right_speed  (o_drive.right_speed),
    .i_error_scaled (o_drive.error_scaled)
);
